// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pci_pkg.sv =====
// Shared types, constants, saturation helpers and step sequencing for the PID controller.
// No dependencies.
`timescale 1ns / 1ps

package pci_pkg;

    // Configuration register indexes
    localparam logic [2:0] RegPropGain  = 3'd0;
    localparam logic [2:0] RegIntegGain = 3'd1;
    localparam logic [2:0] RegDerivGain = 3'd2;
    localparam logic [2:0] RegTarget    = 3'd3;
    localparam logic [2:0] RegDriveMin  = 3'd4;
    localparam logic [2:0] RegDriveMax  = 3'd5;
    localparam logic [2:0] RegSampleMs  = 3'd6;
    localparam logic [2:0] RegEnable    = 3'd7;

    localparam logic OpSample = 1'b0;
    localparam logic OpReset  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [31:0] PropGainRst = 32'd65536;
    localparam logic [31:0] DriveMaxRst = 32'd6553600;
    localparam logic [15:0] SampleMsRst = 16'd1000;

    // Constant divisors and scale
    localparam logic [31:0] MsPerSec   = 32'd1000;
    localparam logic [31:0] CeilDiv    = 32'd10;
    localparam logic [31:0] FiltDiv    = 32'd5;

    // Last iteration index of each operation in the serial unit
    localparam logic [5:0] MulLast = 6'd31;
    localparam logic [5:0] DivLast = 6'd63;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINAL,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        ST_PTERM,
        ST_INCM,
        ST_INCD,
        ST_ICAND,
        ST_DOLD,
        ST_CEIL,
        ST_ITERM,
        ST_DIFFM,
        ST_RAWD,
        ST_FILTD,
        ST_DTERM
    } step_t;

    typedef enum logic {
        AOP_MUL,
        AOP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Scale a Q16.16 gain product back down, floor, and saturate
    function automatic logic signed [31:0] gsat(input logic signed [64:0] p);
        logic signed [48:0] s;
        s = p[64:16];
        return sat32(65'(s));
    endfunction

    function automatic step_t step_succ(input step_t s);
        step_t n;
        unique case (s)
            ST_PTERM: n = ST_INCM;
            ST_INCM:  n = ST_INCD;
            ST_INCD:  n = ST_ICAND;
            ST_ICAND: n = ST_DOLD;
            ST_DOLD:  n = ST_CEIL;
            ST_CEIL:  n = ST_ITERM;
            ST_ITERM: n = ST_DIFFM;
            ST_DIFFM: n = ST_RAWD;
            ST_RAWD:  n = ST_FILTD;
            ST_FILTD: n = ST_DTERM;
            default:  n = ST_DTERM;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/pci_arith.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Depends on pci_pkg.
`timescale 1ns / 1ps

module pci_arith (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pci_pkg::arith_cmd_t      cmd,
    input  logic signed [63:0]       opa,
    input  logic        [31:0]       opb,
    output logic                     done,
    output logic signed [64:0]       result
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    pci_pkg::arith_op_t   op_reg;
    // multiply state
    logic signed [32:0]   a_reg;
    logic signed [33:0]   hi_reg;
    logic [31:0]          lo_reg;
    // divide state
    logic                 neg_reg;
    logic [31:0]          rem_reg;
    logic [63:0]          quo_reg;
    logic [31:0]          dvs_reg;

    logic signed [33:0]   mul_sum;
    logic [32:0]          div_shift;
    logic                 div_fit;
    logic [63:0]          q_adj;
    logic signed [63:0]   div_res;

    // one multiplier bit per cycle
    assign mul_sum   = hi_reg + (lo_reg[0] ? 34'(a_reg) : 34'sd0);
    // one quotient bit per cycle
    assign div_shift = {rem_reg, quo_reg[63]};
    assign div_fit   = div_shift >= {1'b0, dvs_reg};

    // floor correction for a negative dividend
    assign q_adj   = quo_reg + 64'(rem_reg != 32'd0);
    assign div_res = neg_reg ? -$signed(q_adj) : $signed(quo_reg);

    assign result = (op_reg == pci_pkg::AOP_MUL) ? $signed({hi_reg[32:0], lo_reg})
                                                 : 65'(div_res);
    assign done   = done_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (cmd.op == pci_pkg::AOP_MUL) ? pci_pkg::MulLast
                                                          : pci_pkg::DivLast;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= cmd.op;
            a_reg   <= opa[32:0];
            hi_reg  <= '0;
            lo_reg  <= opb;
            neg_reg <= opa[63];
            quo_reg <= opa[63] ? 64'(-opa) : 64'(opa);
            rem_reg <= '0;
            dvs_reg <= opb;
        end else if (busy_reg) begin
            if (op_reg == pci_pkg::AOP_MUL) begin
                hi_reg <= {mul_sum[33], mul_sum[33:1]};
                lo_reg <= {mul_sum[0], lo_reg[31:1]};
            end else begin
                rem_reg <= div_fit ? 32'(div_shift - {1'b0, dvs_reg}) : div_shift[31:0];
                quo_reg <= {quo_reg[62:0], div_fit};
            end
        end
    end

endmodule

// ===== rtl/pid_conditional_integration.sv =====
// Top level of the PID controller with conditional integration.
// Depends on pci_pkg and pci_arith.
`timescale 1ns / 1ps

// PID controller, signed Q16.16, one result per item. Reset commands, disabled
// samples and cached samples (less than sample_time_ms, or no time at all, since
// the last update) go straight to the output state: the result posts to the
// output register once it is free, and the input is ready again as it posts.
// A fresh computation runs eleven operations through one shared bit-serial unit:
// seven multiplies and four divides, each issued and then awaited until the unit
// is done and its result is captured, then a finish state and the output state
// post the result. That unit sets the rate; one item is in work at a time, and
// a finished result waits in the output register while the next item is taken.
module pid_conditional_integration (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic signed [31:0] s_measurement,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_control_output,
    output logic               m_fresh
);

    // configuration
    logic [31:0]        prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [31:0] target_reg, dmin_reg, dmax_reg;
    logic [15:0]        sample_ms_reg;
    logic               enable_reg;

    // controller state
    logic [31:0]        last_ms_reg;
    logic               tvalid_reg, seeded_reg;
    logic signed [31:0] prev_reg, filt_reg, integ_reg, held_reg;

    // work registers
    logic signed [31:0] meas_reg, err_reg, pterm_reg, cand_reg, ti_reg, td_reg;
    logic signed [31:0] iterm_reg, raw_reg, dterm_reg;
    logic [31:0]        elapsed_reg;
    logic signed [64:0] wide_reg;
    logic signed [31:0] res_val_reg;
    logic               res_fresh_reg;
    logic               m_valid_reg, m_fresh_reg;
    logic signed [31:0] m_out_reg;

    pci_pkg::state_t    state_reg, state_next;
    pci_pkg::step_t     step_reg;

    pci_pkg::arith_cmd_t cmd;
    pci_pkg::arith_op_t  a_op;
    logic                a_start;
    logic signed [63:0]  opa;
    logic [31:0]         opb;
    logic                a_done;
    logic signed [64:0]  a_res;

    logic               accept, out_free, go_compute;
    logic [31:0]        lu, elapsed;
    logic signed [31:0] err_in;
    logic signed [32:0] range_d, diff_d;
    logic signed [34:0] unclamped, outsum, lim_v;
    logic signed [31:0] ceil_v, ni, outv;
    logic               grow;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // timing of the incoming sample
    assign lu         = tvalid_reg ? last_ms_reg : s_now_ms - 32'(sample_ms_reg);
    assign elapsed    = s_now_ms - lu;
    assign err_in     = pci_pkg::sat32(65'(target_reg) - 65'(s_measurement));
    assign go_compute = (s_opcode == pci_pkg::OpSample) && enable_reg
                        && (elapsed >= 32'(sample_ms_reg)) && (elapsed != 32'd0);

    // combine terms and pick the integral update
    assign range_d   = 33'(dmax_reg) - 33'(dmin_reg);
    assign diff_d    = 33'(meas_reg) - 33'(prev_reg);
    assign unclamped = 35'(pterm_reg) + 35'(ti_reg) - 35'(td_reg);
    assign grow      = ((unclamped >= 35'(dmin_reg)) && (unclamped <= 35'(dmax_reg)))
                       || ((unclamped > 35'(dmax_reg)) && err_reg[31])
                       || ((unclamped < 35'(dmin_reg)) && (err_reg > 32'sd0));
    assign ceil_v    = pci_pkg::sat32(a_res);
    assign ni        = grow ? cand_reg : integ_reg;

    // final drive value at full width, drive_min wins over drive_max
    assign outsum = 35'(pterm_reg) + 35'(iterm_reg) - 35'(dterm_reg);
    always_comb begin
        lim_v = (outsum > 35'(dmax_reg)) ? 35'(dmax_reg) : outsum;
        outv  = (lim_v < 35'(dmin_reg)) ? dmin_reg : lim_v[31:0];
    end

    // operands for the shared unit
    always_comb begin
        opa = '0;
        opb = '0;
        a_op = pci_pkg::AOP_MUL;
        unique case (step_reg)
            pci_pkg::ST_PTERM: begin
                opa = 64'(err_reg);   opb = prop_gain_reg;
            end
            pci_pkg::ST_INCM: begin
                opa = 64'(err_reg);   opb = elapsed_reg;
            end
            pci_pkg::ST_INCD: begin
                opa = wide_reg[63:0]; opb = pci_pkg::MsPerSec; a_op = pci_pkg::AOP_DIV;
            end
            pci_pkg::ST_ICAND: begin
                opa = 64'(cand_reg);  opb = integ_gain_reg;
            end
            pci_pkg::ST_DOLD: begin
                opa = 64'(filt_reg);  opb = deriv_gain_reg;
            end
            pci_pkg::ST_CEIL: begin
                opa = 64'(35'(range_d) + (35'(range_d) <<< 1));
                opb = pci_pkg::CeilDiv; a_op = pci_pkg::AOP_DIV;
            end
            pci_pkg::ST_ITERM: begin
                opa = 64'(integ_reg); opb = integ_gain_reg;
            end
            pci_pkg::ST_DIFFM: begin
                opa = 64'(diff_d);    opb = pci_pkg::MsPerSec;
            end
            pci_pkg::ST_RAWD: begin
                opa = wide_reg[63:0]; opb = elapsed_reg; a_op = pci_pkg::AOP_DIV;
            end
            pci_pkg::ST_FILTD: begin
                opa = 64'((35'(filt_reg) <<< 2) + 35'(raw_reg));
                opb = pci_pkg::FiltDiv; a_op = pci_pkg::AOP_DIV;
            end
            default: begin
                opa = 64'(filt_reg);  opb = deriv_gain_reg;
            end
        endcase
    end

    assign cmd = '{start: a_start, op: a_op};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pci_pkg::S_IDLE:  if (accept) begin
                state_next = go_compute ? pci_pkg::S_ISSUE : pci_pkg::S_OUT;
            end
            pci_pkg::S_ISSUE: state_next = pci_pkg::S_WAIT;
            pci_pkg::S_WAIT:  if (a_done) begin
                state_next = (step_reg == pci_pkg::ST_DTERM) ? pci_pkg::S_FINAL
                                                             : pci_pkg::S_ISSUE;
            end
            pci_pkg::S_FINAL: state_next = pci_pkg::S_OUT;
            pci_pkg::S_OUT:   if (out_free) begin
                state_next = pci_pkg::S_IDLE;
            end
            default:          state_next = pci_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready = (state_reg == pci_pkg::S_IDLE);
        a_start = (state_reg == pci_pkg::S_ISSUE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pci_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    pci_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .done    (a_done),
        .result  (a_res)
    );

    // configuration, controller state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= pci_pkg::PropGainRst;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            target_reg     <= '0;
            dmin_reg       <= '0;
            dmax_reg       <= pci_pkg::DriveMaxRst;
            sample_ms_reg  <= pci_pkg::SampleMsRst;
            enable_reg     <= 1'b1;
            last_ms_reg    <= '0;
            tvalid_reg     <= 1'b0;
            seeded_reg     <= 1'b0;
            prev_reg       <= '0;
            filt_reg       <= '0;
            integ_reg      <= '0;
            held_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    pci_pkg::RegPropGain:  prop_gain_reg  <= cfg_wdata;
                    pci_pkg::RegIntegGain: integ_gain_reg <= cfg_wdata;
                    pci_pkg::RegDerivGain: deriv_gain_reg <= cfg_wdata;
                    pci_pkg::RegTarget:    target_reg     <= cfg_wdata;
                    pci_pkg::RegDriveMin:  dmin_reg       <= cfg_wdata;
                    pci_pkg::RegDriveMax:  dmax_reg       <= cfg_wdata;
                    pci_pkg::RegSampleMs:  sample_ms_reg  <= cfg_wdata[15:0];
                    pci_pkg::RegEnable: begin
                        enable_reg <= cfg_wdata[0];
                        if (!cfg_wdata[0]) begin
                            integ_reg   <= '0;
                            filt_reg    <= '0;
                            held_reg    <= '0;
                            last_ms_reg <= '0;
                            tvalid_reg  <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            // take an item
            if (accept) begin
                res_fresh_reg <= 1'b0;
                if (s_opcode == pci_pkg::OpReset) begin
                    integ_reg   <= '0;
                    filt_reg    <= '0;
                    held_reg    <= '0;
                    last_ms_reg <= '0;
                    tvalid_reg  <= 1'b0;
                    res_val_reg <= '0;
                end else if (!enable_reg) begin
                    res_val_reg <= '0;
                end else begin
                    tvalid_reg <= 1'b1;
                    if (!tvalid_reg && !seeded_reg) begin
                        prev_reg   <= s_measurement;
                        seeded_reg <= 1'b1;
                    end
                    meas_reg    <= s_measurement;
                    elapsed_reg <= elapsed;
                    err_reg     <= err_in;
                    res_val_reg <= held_reg;
                    last_ms_reg <= (elapsed < 32'(sample_ms_reg)) ? lu : s_now_ms;
                end
            end

            // integral commit at the ceiling step, filter commit at the filter step
            if ((state_reg == pci_pkg::S_WAIT) && a_done
                && (step_reg == pci_pkg::ST_CEIL)) begin
                if (ni > ceil_v) begin
                    integ_reg <= ceil_v;
                end else if (ni < 32'sd0) begin
                    integ_reg <= '0;
                end else begin
                    integ_reg <= ni;
                end
            end
            if ((state_reg == pci_pkg::S_WAIT) && a_done
                && (step_reg == pci_pkg::ST_FILTD)) begin
                filt_reg <= pci_pkg::sat32(a_res);
            end

            // finish a fresh computation
            if (state_reg == pci_pkg::S_FINAL) begin
                held_reg      <= outv;
                prev_reg      <= meas_reg;
                res_val_reg   <= outv;
                res_fresh_reg <= 1'b1;
            end

            // output register
            if ((state_reg == pci_pkg::S_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
                m_out_reg   <= res_val_reg;
                m_fresh_reg <= res_fresh_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // capture results of the shared unit
    always_ff @(posedge aclk) begin
        if (accept) begin
            step_reg <= pci_pkg::ST_PTERM;
        end else if ((state_reg == pci_pkg::S_WAIT) && a_done) begin
            step_reg <= pci_pkg::step_succ(step_reg);
            case (step_reg)
                pci_pkg::ST_PTERM: pterm_reg <= pci_pkg::gsat(a_res);
                pci_pkg::ST_INCM:  wide_reg  <= a_res;
                pci_pkg::ST_INCD:  cand_reg  <= pci_pkg::sat32(65'(integ_reg) + a_res);
                pci_pkg::ST_ICAND: ti_reg    <= pci_pkg::gsat(a_res);
                pci_pkg::ST_DOLD:  td_reg    <= pci_pkg::gsat(a_res);
                pci_pkg::ST_ITERM: iterm_reg <= pci_pkg::gsat(a_res);
                pci_pkg::ST_DIFFM: wide_reg  <= a_res;
                pci_pkg::ST_RAWD:  raw_reg   <= pci_pkg::sat32(a_res);
                pci_pkg::ST_DTERM: dterm_reg <= pci_pkg::gsat(a_res);
                default: ;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_control_output = m_out_reg;
    assign m_fresh          = m_fresh_reg;

endmodule

// ===== rtl/pci_checker.sv =====
// Port-level checks for the PID controller, bound to the top level.
// Depends on assert_macros.svh and pid_conditional_integration.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pci_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_control_output,
    input logic               m_fresh
);

    // one item in work at a time
    `AST_NEXT(a_busy_after_take, s_valid && s_ready, !s_ready, "input taken while busy")
    // posting a result frees the input side
    `AST_IMPL(a_ready_on_post, $rose(m_valid), s_ready, "not ready after posting result")
    // a stalled result holds
    `AST_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_control_output) && $stable(m_fresh), "result dropped")

endmodule

bind pid_conditional_integration pci_checker u_pci_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_control_output (m_control_output),
    .m_fresh          (m_fresh)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for pid_conditional_integration.
// Depends on pci_pkg and the controller RTL; predicts each drive value in Q16.16.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic signed [31:0] drive;
        logic               fresh;
    } drive_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_opcode;
    logic signed [31:0] s_measurement;
    logic [31:0]        s_now_ms;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_control_output;
    logic               m_fresh;

    pid_conditional_integration i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_measurement    (s_measurement),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_control_output (m_control_output),
        .m_fresh          (m_fresh)
    );

    // Controller model: configuration
    logic [31:0] kp, ki, kd;
    longint      setpoint, lo_clamp, hi_clamp;
    logic [15:0] period_ms;
    bit          run_en;
    // Controller model: state
    logic [31:0] last_ms;
    bit          timing_ok, primed;
    longint      prev_meas, filt_deriv, integ_acc, hold_drive;

    drive_t      drive_q[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          drives_seen = 0;
    int          fresh_seen = 0;
    int          burst_left = 0;
    logic [31:0] sim_ms = 32'd5000;
    int          hold_req = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_tick = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint gain_mul(logic [31:0] g, longint x);
        return sat_q(floor_div(longint'(g) * x, 65536));
    endfunction

    function automatic void clear_loop();
        integ_acc  = 0;
        filt_deriv = 0;
        hold_drive = 0;
        last_ms    = '0;
        timing_ok  = 0;
    endfunction

    function automatic void model_reset();
        kp = pci_pkg::PropGainRst; ki = '0; kd = '0;
        setpoint = 0; lo_clamp = 0; hi_clamp = longint'(signed'(pci_pkg::DriveMaxRst));
        period_ms = pci_pkg::SampleMsRst; run_en = 1;
        clear_loop();
        primed = 0;
        prev_meas = 0;
    endfunction

    function automatic void model_config(logic [2:0] idx, logic [31:0] val);
        case (idx)
            pci_pkg::RegPropGain:  kp = val;
            pci_pkg::RegIntegGain: ki = val;
            pci_pkg::RegDerivGain: kd = val;
            pci_pkg::RegTarget:    setpoint = longint'(signed'(val));
            pci_pkg::RegDriveMin:  lo_clamp = longint'(signed'(val));
            pci_pkg::RegDriveMax:  hi_clamp = longint'(signed'(val));
            pci_pkg::RegSampleMs:  period_ms = val[15:0];
            pci_pkg::RegEnable: begin
                run_en = val[0];
                if (!val[0]) clear_loop();
            end
            default: ;
        endcase
    endfunction

    // Work out the drive value caused by one accepted item
    function automatic drive_t predict_drive(logic op, logic signed [31:0] meas_in,
                                             logic [31:0] now);
        drive_t r;
        longint meas, err, pterm, cand, unclamped, ceil_i, iterm, raw, dterm, outv;
        logic [31:0] elapsed;
        bit grow;
        meas = longint'(meas_in);
        r.drive = '0;
        r.fresh = 1'b0;
        if (op == pci_pkg::OpReset) begin
            clear_loop();
            return r;
        end
        if (!run_en) return r;
        if (!timing_ok) begin
            last_ms = now - {16'd0, period_ms};
            timing_ok = 1;
            if (!primed) begin
                prev_meas = meas;
                primed = 1;
            end
        end
        elapsed = now - last_ms;
        r.drive = hold_drive[31:0];
        if (elapsed < {16'd0, period_ms}) return r;
        last_ms = now;
        if (elapsed == 0) return r;

        err = sat_q(setpoint - meas);
        pterm = gain_mul(kp, err);
        cand = sat_q(integ_acc + floor_div(err * longint'(elapsed), 1000));
        unclamped = pterm + gain_mul(ki, cand) - gain_mul(kd, filt_deriv);
        // Conditional integration: grow only in range or when heading back in
        grow = (unclamped >= lo_clamp && unclamped <= hi_clamp)
            || (unclamped > hi_clamp && err < 0)
            || (unclamped < lo_clamp && err > 0);
        if (grow) integ_acc = cand;
        ceil_i = sat_q(floor_div(3 * (hi_clamp - lo_clamp), 10));
        if (integ_acc > ceil_i) integ_acc = ceil_i;
        else if (integ_acc < 0) integ_acc = 0;
        iterm = gain_mul(ki, integ_acc);

        // Derivative on measurement, low-pass filtered
        raw = sat_q(floor_div((meas - prev_meas) * 1000, longint'(elapsed)));
        filt_deriv = sat_q(floor_div(4 * filt_deriv + raw, 5));
        dterm = gain_mul(kd, filt_deriv);
        prev_meas = meas;

        outv = pterm + iterm - dterm;
        if (outv > hi_clamp) outv = hi_clamp;
        if (outv < lo_clamp) outv = lo_clamp;
        hold_drive = outv;
        r.drive = outv[31:0];
        r.fresh = 1'b1;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Send one item in bursts with random gaps; predict on acceptance
    task automatic send_item(input logic op, input logic signed [31:0] meas,
                             input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_measurement <= meas;
        s_now_ms      <= now;
        do @(posedge aclk); while (!s_ready);
        drive_q.push_back(predict_drive(op, meas, now));
        burst_left--;
        items_sent++;
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
    endtask

    // Hold until every expected drive value has come back
    task automatic wait_drained();
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        model_config(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: own stall pattern plus long hold-offs on request
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 300 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) < 6);
                2: m_ready <= (rx_tick % 7 < 3);
                default: m_ready <= ($urandom_range(0, 19) != 0);
            endcase
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        drive_t want;
        if (aresetn && m_valid && m_ready) begin
            drives_seen++;
            if (drive_q.size() == 0) begin
                report("unexpected result", m_control_output, 0);
            end else begin
                want = drive_q.pop_front();
                if (m_control_output !== want.drive)
                    report("control_output", m_control_output, want.drive);
                if (m_fresh !== want.fresh)
                    report("fresh", m_fresh, want.fresh);
                if (want.fresh) fresh_seen++;
            end
        end
    end

    // Next timestamp: mostly due, some cached, a few jumps anywhere
    task automatic send_sample(input logic signed [31:0] meas);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) sim_ms += period_ms + $urandom_range(0, period_ms / 4 + 2);
        else if (r < 90) sim_ms += $urandom_range(0, (period_ms > 0) ? period_ms - 1 : 0);
        else sim_ms = $urandom();
        send_item(pci_pkg::OpSample, meas, sim_ms);
    endtask

    function automatic logic signed [31:0] near_setpoint();
        logic signed [31:0] off;
        if ($urandom_range(0, 4) == 0) return $urandom();
        off = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
        return setpoint[31:0] + off;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 4 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd65535;
            3: return 32'hFFFF_0000 | $urandom_range(1, 500);
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    task automatic random_config();
        longint lo, span;
        write_reg(pci_pkg::RegPropGain, pick_gain());
        write_reg(pci_pkg::RegIntegGain, pick_gain());
        write_reg(pci_pkg::RegDerivGain, pick_gain());
        if ($urandom_range(0, 4) == 0) begin
            write_reg(pci_pkg::RegTarget, $urandom());
            write_reg(pci_pkg::RegDriveMin, $urandom());
            write_reg(pci_pkg::RegDriveMax, $urandom());
        end else begin
            lo = $signed($urandom_range(0, 200 * 65536)) - 100 * 65536;
            span = $urandom_range(0, 200 * 65536);
            write_reg(pci_pkg::RegTarget, 32'(lo + $urandom_range(0, 200 * 65536)));
            write_reg(pci_pkg::RegDriveMin, 32'(lo));
            write_reg(pci_pkg::RegDriveMax, 32'(lo + span));
        end
        write_reg(pci_pkg::RegSampleMs, pick_period());
        write_reg(pci_pkg::RegEnable, {31'd0, ($urandom_range(0, 9) != 0)});
    endtask

    task automatic test_directed();
        send_item(pci_pkg::OpSample, 32'sh000A_0000, 32'd5000);    // first sample, fresh at once
        send_item(pci_pkg::OpSample, 32'sh000B_0000, 32'd5500);    // cached
        send_item(pci_pkg::OpSample, 32'sh0014_0000, 32'd6000);
        send_item(pci_pkg::OpReset, 32'sh1234_5678, 32'hFFFF_FFFF);
        send_item(pci_pkg::OpSample, 32'sh0015_0000, 32'd6100);    // first after reset
        stop_sending();
        wait_drained();
        write_reg(pci_pkg::RegIntegGain, 32'h0001_0000);
        write_reg(pci_pkg::RegDerivGain, 32'h0000_8000);
        write_reg(pci_pkg::RegTarget, 32'h0032_0000);
        send_item(pci_pkg::OpSample, 32'sh7FFF_FFFF, 32'd7200);
        send_item(pci_pkg::OpSample, 32'sh8000_0000, 32'd8300);
        send_item(pci_pkg::OpSample, 32'sh0000_0000, 32'hFFFF_FF00);
        send_item(pci_pkg::OpSample, 32'sh0030_0000, 32'h0000_02F0);  // timestamp wrap
        stop_sending();
        wait_drained();
        // Inverted clamps: minimum wins, ceiling negative
        write_reg(pci_pkg::RegDriveMin, 32'h0064_0000);
        write_reg(pci_pkg::RegDriveMax, 32'h000A_0000);
        send_item(pci_pkg::OpSample, 32'sh0010_0000, 32'h0000_0700);
        send_item(pci_pkg::OpSample, 32'sh0090_0000, 32'h0000_0B00);
        stop_sending();
        wait_drained();
        // Zero sample period: zero elapsed holds
        write_reg(pci_pkg::RegDriveMin, 32'h8000_0000);
        write_reg(pci_pkg::RegDriveMax, 32'h7FFF_FFFF);
        write_reg(pci_pkg::RegSampleMs, 32'd0);
        send_item(pci_pkg::OpSample, 32'sh0001_0000, 32'd100);
        send_item(pci_pkg::OpSample, 32'sh0002_0000, 32'd100);
        send_item(pci_pkg::OpSample, 32'sh0003_0000, 32'd101);
        stop_sending();
        wait_drained();
        // Disabled samples give zero; enabling resumes from a cleared loop
        write_reg(pci_pkg::RegEnable, 32'd0);
        send_item(pci_pkg::OpSample, 32'sh0005_0000, 32'd2000);
        send_item(pci_pkg::OpSample, 32'sh0006_0000, 32'd3000);
        stop_sending();
        wait_drained();
        write_reg(pci_pkg::RegEnable, 32'd1);
        write_reg(pci_pkg::RegSampleMs, 32'd65535);
        write_reg(pci_pkg::RegPropGain, 32'hFFFF_FFFF);
        send_item(pci_pkg::OpSample, 32'sh0007_0000, 32'd4000);
        send_item(pci_pkg::OpSample, 32'sh0008_0000, 32'd70000);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            random_config();
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 39) == 0)
                    send_item(pci_pkg::OpReset, $urandom(), $urandom());
                else
                    send_sample(near_setpoint());
            end
            // Pause the sender until every result is back
            stop_sending();
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        write_reg(pci_pkg::RegSampleMs, 32'd10);
        write_reg(pci_pkg::RegEnable, 32'd1);
        hold_req = 400;
        for (int k = 0; k < 40; k++) send_sample(near_setpoint());
        stop_sending();
        wait_drained();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_opcode  <= pci_pkg::OpSample;
        s_measurement <= '0;
        s_now_ms  <= '0;
        model_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_phases(20, 85);
        test_backpressure();

        stop_sending();
        wait_drained();
        repeat (50) @(posedge aclk);
        $display("Sent %0d items (samples, reset commands, disabled and cached cases)", items_sent);
        $display("Checked %0d results, %0d fresh, across 22 register settings", drives_seen,
                 fresh_seen);
        if (mismatches == 0 && drive_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, drive_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #60_000_000;
        $display("Timeout with %0d results outstanding", drive_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
